// ===== hw/rtl/gerw_pkg.sv =====
// ----------------------------------------------------------------------------
// gerw_pkg
// Types and constants shared by the grey erosion block and its checker.
// ----------------------------------------------------------------------------
`default_nettype none

package gerw_pkg;

  localparam int unsigned MAX_WIDTH_DEF  = 1024;
  localparam int unsigned MAX_RADIUS_DEF = 7;
  localparam int unsigned MAX_HEIGHT     = 4096;
  localparam int unsigned WIDTH_W        = 11;
  localparam int unsigned HEIGHT_W       = 13;
  localparam int unsigned RADIUS_W       = 3;
  localparam int unsigned CFG_DATA_W     = 13;
  localparam int unsigned CFG_IDX_W      = 2;
  localparam int unsigned CNT_W          = WIDTH_W + HEIGHT_W;
  localparam logic [7:0]  PAD_VALUE      = 8'd255;

  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_X = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_RADIUS_Y = 2'd3;

  localparam logic CMD_PUSH  = 1'b0;
  localparam logic CMD_DRAIN = 1'b1;

  typedef struct packed {
    logic       cmd;
    logic [7:0] pixel;
  } in_req_t;

  typedef struct packed {
    logic [7:0] eroded;
    logic       frame_end;
  } out_res_t;

endpackage

`default_nettype wire

// ===== hw/rtl/grey_erosion_rect_window.sv =====
// ----------------------------------------------------------------------------
// grey_erosion_rect_window
// Streaming grey erosion with a rectangular window over a line memory.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_req_i) carries raster pixels
//   (cmd push) or drain ticks (cmd drain) after the last pixel of a frame.
//   Output channel (out_valid_o/out_ready_i/out_res_o) carries the window
//   minimum of each pixel in raster order, frame_end on the last one.
//   Config: cfg_we_i writes register cfg_idx_i (width, height, radius x,
//   radius y); any write restarts the frame.
//   A request that yields no result is taken while idle. One that
//   yields a result scans the clipped window through the single read port
//   of the line memory, one pixel a cycle, rows*cols pixels, at most
//   (2*MaxRadius+1)^2; no new request is taken until the result is loaded.
//   Output number i appears on input pixel i + radius_y*width + radius_x.
//   Reset clears counters and the output valid flag; the line memory needs
//   no clearing since only written entries are read.
//   A result waiting on a stalled receiver sits in the output register;
//   further requests are taken until the next result must be loaded.
// ----------------------------------------------------------------------------
`default_nettype none

module grey_erosion_rect_window #(
  parameter int unsigned MaxWidth  = gerw_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MaxRadius = gerw_pkg::MAX_RADIUS_DEF
) (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire gerw_pkg::in_req_t              in_req_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output gerw_pkg::out_res_t                  out_res_o,
  input  wire logic                           cfg_we_i,
  input  wire logic [gerw_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  wire logic [gerw_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import gerw_pkg::*;

  localparam int unsigned StoreRows = 2 * MaxRadius + 1;
  localparam int unsigned SlotW     = $clog2(StoreRows);
  localparam int unsigned ColW      = $clog2(MaxWidth);
  localparam int unsigned XW        = (ColW > WIDTH_W) ? ColW : WIDTH_W;
  localparam int unsigned AddrW     = SlotW + ColW;
  localparam int unsigned Depth     = StoreRows * (2 ** ColW);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SCAN = 4'b0010,
    ST_WAIT = 4'b0100,
    ST_PUSH = 4'b1000
  } state_e;

  state_e state_q;

  // configuration
  logic [WIDTH_W-1:0]  width_q;
  logic [HEIGHT_W-1:0] height_q;
  logic [RADIUS_W-1:0] rx_q, ry_q;

  logic [WIDTH_W-1:0]  eff_w;
  logic [HEIGHT_W-1:0] eff_h;
  logic [RADIUS_W-1:0] eff_rx, eff_ry;
  logic [CNT_W-1:0]    total, delay;

  always_comb begin
    if (width_q == '0) eff_w = WIDTH_W'(1);
    else if (32'(width_q) > MaxWidth) eff_w = WIDTH_W'(MaxWidth);
    else eff_w = width_q;
    if (height_q == '0) eff_h = HEIGHT_W'(1);
    else if (32'(height_q) > MAX_HEIGHT) eff_h = HEIGHT_W'(MAX_HEIGHT);
    else eff_h = height_q;
    eff_rx = (32'(rx_q) > MaxRadius) ? RADIUS_W'(MaxRadius) : rx_q;
    eff_ry = (32'(ry_q) > MaxRadius) ? RADIUS_W'(MaxRadius) : ry_q;
    total  = CNT_W'(eff_w) * CNT_W'(eff_h);
    delay  = CNT_W'(eff_ry) * CNT_W'(eff_w) + CNT_W'(eff_rx);
  end

  // counters
  logic [CNT_W-1:0]    in_cnt_q, out_cnt_q;
  logic [XW-1:0]       in_col_q, out_x_q;
  logic [SlotW-1:0]    in_slot_q, out_slot_q;
  logic [HEIGHT_W-1:0] out_y_q;

  // window scan
  logic [XW-1:0]       su_q, u0_q, u1_q;
  logic [HEIGHT_W-1:0] sv_q, v1_q;
  logic [SlotW-1:0]    sslot_q;
  logic [7:0]          min_q;
  logic                rd_vld_q;
  logic [7:0]          rdata_q;
  logic [7:0]          mem [Depth];

  logic in_acc, out_free, start;
  logic [XW-1:0]       wm1, x_lo, x_hi;
  logic [HEIGHT_W-1:0] hm1, y_hi;
  logic [RADIUS_W-1:0] dy;
  logic                last_rd;
  logic [CNT_W-1:0]    out_next;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_acc     = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_o || out_ready_i;
  assign out_next   = out_cnt_q + CNT_W'(1);

  always_comb begin
    start = 1'b0;
    if (in_acc) begin
      if (in_req_i.cmd == CMD_DRAIN) start = (in_cnt_q >= total);
      else start = (in_cnt_q < total) && (in_cnt_q >= out_cnt_q + delay);
    end
  end

  always_comb begin
    wm1  = XW'(eff_w) - XW'(1);
    hm1  = eff_h - HEIGHT_W'(1);
    x_lo = (out_x_q > XW'(eff_rx)) ? out_x_q - XW'(eff_rx) : '0;
    x_hi = ((out_x_q + XW'(eff_rx)) > wm1) ? wm1 : out_x_q + XW'(eff_rx);
    y_hi = ((out_y_q + HEIGHT_W'(eff_ry)) > hm1) ? hm1 : out_y_q + HEIGHT_W'(eff_ry);
    dy   = (out_y_q > HEIGHT_W'(eff_ry)) ? eff_ry : RADIUS_W'(out_y_q);
    last_rd = (su_q == u1_q) && (sv_q == v1_q);
  end

  // line memory
  always_ff @(posedge clk_i) begin
    if (in_acc && in_req_i.cmd == CMD_PUSH && in_cnt_q < total) begin
      mem[{in_slot_q, in_col_q[ColW-1:0]}] <= in_req_i.pixel;
    end
    if (state_q == ST_SCAN) begin
      rdata_q <= mem[AddrW'({sslot_q, su_q[ColW-1:0]})];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      width_q     <= WIDTH_W'(1024);
      height_q    <= HEIGHT_W'(1024);
      rx_q        <= RADIUS_W'(1);
      ry_q        <= RADIUS_W'(1);
      in_cnt_q    <= '0;
      out_cnt_q   <= '0;
      in_col_q    <= '0;
      out_x_q     <= '0;
      in_slot_q   <= '0;
      out_slot_q  <= '0;
      out_y_q     <= '0;
      rd_vld_q    <= 1'b0;
      out_valid_o <= 1'b0;
    end else begin
      rd_vld_q <= (state_q == ST_SCAN);
      if (out_valid_o && out_ready_i) out_valid_o <= 1'b0;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          REG_WIDTH:    width_q  <= cfg_data_i[WIDTH_W-1:0];
          REG_HEIGHT:   height_q <= cfg_data_i[HEIGHT_W-1:0];
          REG_RADIUS_X: rx_q     <= cfg_data_i[RADIUS_W-1:0];
          REG_RADIUS_Y: ry_q     <= cfg_data_i[RADIUS_W-1:0];
          default: ;
        endcase
        in_cnt_q   <= '0;
        out_cnt_q  <= '0;
        in_col_q   <= '0;
        out_x_q    <= '0;
        in_slot_q  <= '0;
        out_slot_q <= '0;
        out_y_q    <= '0;
      end else begin
        unique case (state_q)
          ST_IDLE: begin
            if (in_acc && in_req_i.cmd == CMD_PUSH && in_cnt_q < total) begin
              in_cnt_q <= in_cnt_q + CNT_W'(1);
              if (in_col_q == wm1) begin
                in_col_q  <= '0;
                in_slot_q <= (32'(in_slot_q) == StoreRows - 1) ? '0 : in_slot_q + SlotW'(1);
              end else begin
                in_col_q <= in_col_q + XW'(1);
              end
            end
            if (start) state_q <= ST_SCAN;
          end
          ST_SCAN: begin
            if (last_rd) state_q <= ST_WAIT;
          end
          ST_WAIT: state_q <= ST_PUSH;
          ST_PUSH: begin
            if (out_free) begin
              out_valid_o <= 1'b1;
              state_q     <= ST_IDLE;
              if (out_next >= total) begin
                in_cnt_q   <= '0;
                out_cnt_q  <= '0;
                in_col_q   <= '0;
                out_x_q    <= '0;
                in_slot_q  <= '0;
                out_slot_q <= '0;
                out_y_q    <= '0;
              end else begin
                out_cnt_q <= out_next;
                if (out_x_q == wm1) begin
                  out_x_q    <= '0;
                  out_y_q    <= out_y_q + HEIGHT_W'(1);
                  out_slot_q <= (32'(out_slot_q) == StoreRows - 1) ? '0
                                                                   : out_slot_q + SlotW'(1);
                end else begin
                  out_x_q <= out_x_q + XW'(1);
                end
              end
            end
          end
          default: state_q <= ST_IDLE;
        endcase
      end
    end
  end

  // scan set-up, scan address stepping, running minimum and result data
  always_ff @(posedge clk_i) begin
    if (start) begin
      u0_q  <= x_lo;
      u1_q  <= x_hi;
      su_q  <= x_lo;
      v1_q  <= y_hi;
      sv_q  <= out_y_q - HEIGHT_W'(dy);
      sslot_q <= (out_slot_q >= SlotW'(dy)) ? out_slot_q - SlotW'(dy)
                                             : SlotW'(32'(out_slot_q) + StoreRows - 32'(dy));
      min_q <= PAD_VALUE;
    end else begin
      if (state_q == ST_SCAN && !last_rd) begin
        if (su_q == u1_q) begin
          su_q    <= u0_q;
          sv_q    <= sv_q + HEIGHT_W'(1);
          sslot_q <= (32'(sslot_q) == StoreRows - 1) ? '0 : sslot_q + SlotW'(1);
        end else begin
          su_q <= su_q + XW'(1);
        end
      end
      if (rd_vld_q && rdata_q < min_q) begin
        min_q <= rdata_q;
      end
    end
    if (state_q == ST_PUSH && out_free) begin
      out_res_o.eroded    <= min_q;
      out_res_o.frame_end <= (out_next >= total);
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/gerw_checker.sv =====
// ----------------------------------------------------------------------------
// gerw_checker
// Port-level checks on the grey erosion block, bound into its module.
// ----------------------------------------------------------------------------
`default_nettype none

module gerw_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_ready_o,
  input wire logic               out_valid_o,
  input wire logic               out_ready_i,
  input wire gerw_pkg::out_res_t out_res_o
);
  import gerw_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("result dropped before taken");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_res_o))
    else $error("stalled result changed");

  // a result is loaded only from the window scan, never straight from idle
  a_res_after_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> !$past(in_ready_o))
    else $error("result appeared without a window scan");

  a_busy_after_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> in_ready_o)
    else $error("block not back to idle after loading a result");

endmodule

bind grey_erosion_rect_window gerw_checker u_gerw_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_o  (in_ready_o),
  .out_valid_o (out_valid_o),
  .out_ready_i (out_ready_i),
  .out_res_o   (out_res_o)
);

`default_nettype wire
